>>> rtl/core/assert_macros.svh
// Assertion macros for the port checker file.
// Needs clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define LMPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmps check failed");
// next-cycle implication
`define LMPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmps check failed");
`endif

>>> rtl/core/lmps_pkg.sv
// Package for the Laplace mixture probability sum core.
// Types, codes and constants; no dependencies.
package lmps_pkg;
  localparam int DEF_MAX_LOCI     = 16;
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam logic [47:0] ACC_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] PROB_MAX = 32'hFFFF_FFFF;
  localparam int PADDR_W = 3;

  typedef enum logic [1:0] {
    ACT_CENTER = 2'd0,
    ACT_WEIGHT = 2'd1,
    ACT_RANGE  = 2'd2,
    ACT_RUN    = 2'd3
  } action_t;

  typedef enum logic {
    REG_LOCI  = 1'b0,
    REG_CLUST = 1'b1
  } reg_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_INIT, ST_VEC, ST_WRD, ST_WGET, ST_LRD, ST_LGET,
    ST_POW, ST_CMUL, ST_LNEXT, ST_CEND, ST_SQ, ST_ACC, ST_INC, ST_DONE
  } st_t;

  typedef struct packed {
    logic        start;
    logic [15:0] p;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] q;
  } div_rsp_t;
endpackage

>>> rtl/core/lmps_if.sv
// Item channel interfaces for the mixture core.
// Depends on nothing.
interface lmps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  cluster;
  logic [3:0]  locus;
  logic [7:0]  allele_a;
  logic [7:0]  allele_b;
  logic [15:0] decay;
  logic [15:0] weight;
  modport source(output valid, action, cluster, locus, allele_a, allele_b, decay, weight,
                 input ready);
  modport sink(input valid, action, cluster, locus, allele_a, allele_b, decay, weight,
               output ready);
endinterface

interface lmps_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] prob_sum;
  logic [47:0] prob_sq_sum;
  logic        saturated;
  modport source(output valid, prob_sum, prob_sq_sum, saturated, input ready);
  modport sink(input valid, prob_sum, prob_sq_sum, saturated, output ready);
endinterface

>>> rtl/core/laplace_mixture_prob_sums_core.sv
// Top level of the discrete Laplace mixture probability sum core.
// Depends on lmps_pkg, lmps_if, lmps_ram and lmps_div.
//
// Usage: items arrive on in_ch (valid/ready). Action centre loads the centre
// allele and decay of one cluster and locus and works out (1-p)/(1+p) on the
// divider. Weight and range loads are written at acceptance and leave the core
// idle. A run item walks every allele vector in the locus ranges, stopping
// early once both sums saturate, and posts one result on out_ch; load items
// give none. One multiplier serves every decay power, component product and
// square in turn. in_ch.ready is low for the whole of a load with division
// or a run. The result sits in an output register; the core takes new items
// while it waits, and a stalled receiver only holds back the end of the next
// run. Reset (rst, synchronous) sets both registers to 1, clears the loop
// state and the output valid; the model tables hold garbage until loaded.
// Registers over APB: loci_in_use at 0x0, clusters_in_use at 0x4.
module laplace_mixture_prob_sums_core
  import lmps_pkg::*;
#(
  parameter int MAX_LOCI     = DEF_MAX_LOCI,
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  logic               clk,
  input  logic               rst,
  lmps_in_if.sink            in_ch,
  lmps_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int LW  = $clog2(MAX_LOCI + 1);
  localparam int CW  = $clog2(MAX_CLUSTERS + 1);
  localparam int LIW = (MAX_LOCI > 1) ? $clog2(MAX_LOCI) : 1;
  localparam int WAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int TD  = MAX_CLUSTERS * MAX_LOCI;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;

  st_t state, state_next;

  logic [4:0]    loci_cfg, clus_cfg;
  logic [LW-1:0] nl, l;
  logic [CW-1:0] nc, c;
  logic [31:0]   comp, total;
  logic [15:0]   f, p_r;
  logic [7:0]    d;
  logic [45:0]   sq_add;
  logic [47:0]   sum_acc, sq_acc;
  logic          sat;
  logic [7:0]    cnt    [MAX_LOCI];
  logic [7:0]    rstart [MAX_LOCI];
  logic [7:0]    rstop  [MAX_LOCI];
  logic [TAW-1:0] h_addr;
  logic [7:0]    h_center;
  logic [15:0]   h_decay;

  logic          ov, o_sat;
  logic [47:0]   o_sum, o_sq;

  logic          acc_in, cfg_wr;
  action_t       act;
  logic          ld_ok_ct, ld_ok_w, ld_ok_r;
  logic [LIW-1:0] li;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [48:0]   s1, s2;
  logic [47:0]   n1, n2;
  logic [32:0]   tsum;
  logic [7:0]    y;
  logic [39:0]   t_rd;
  logic [15:0]   w_rd;
  logic [TAW-1:0] t_raddr;
  logic          out_free;
  div_req_t      dreq;
  div_rsp_t      drsp;

  assign act      = action_t'(in_ch.action);
  assign acc_in   = in_ch.valid && in_ch.ready;
  assign ld_ok_ct = (32'(in_ch.cluster) < MAX_CLUSTERS) && (32'(in_ch.locus) < MAX_LOCI);
  assign ld_ok_w  = 32'(in_ch.cluster) < MAX_CLUSTERS;
  assign ld_ok_r  = 32'(in_ch.locus) < MAX_LOCI;
  assign li       = l[LIW-1:0];
  assign out_free = !ov || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (reg_sel_t'(paddr[2]))
      REG_LOCI:  prdata = {27'b0, loci_cfg};
      REG_CLUST: prdata = {27'b0, clus_cfg};
      default:   prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      loci_cfg <= 5'd1;
      clus_cfg <= 5'd1;
    end else if (cfg_wr) begin
      unique case (reg_sel_t'(paddr[2]))
        REG_LOCI:  loci_cfg <= pwdata[4:0];
        REG_CLUST: clus_cfg <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // divider for the scale factor
  assign dreq.start = acc_in && (act == ACT_CENTER) && ld_ok_ct;
  assign dreq.p     = in_ch.decay;
  lmps_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // centre, decay and scale per cluster and locus
  assign t_raddr = TAW'(32'(c) * MAX_LOCI + 32'(l));
  lmps_ram #(.WIDTH(40), .DEPTH(TD)) u_tab (
    .clk(clk), .we(drsp.done), .waddr(h_addr),
    .wdata({h_center, h_decay, drsp.q}), .raddr(t_raddr), .rdata(t_rd)
  );

  lmps_ram #(.WIDTH(16), .DEPTH(MAX_CLUSTERS)) u_wt (
    .clk(clk), .we(acc_in && (act == ACT_WEIGHT) && ld_ok_w),
    .waddr(WAW'(in_ch.cluster)), .wdata(in_ch.weight),
    .raddr(c[WAW-1:0]), .rdata(w_rd)
  );

  // shared multiplier
  always_comb begin
    unique case (state)
      ST_POW: begin
        mul_a = {16'b0, f};
        mul_b = {16'b0, p_r};
      end
      ST_CMUL: begin
        mul_a = comp;
        mul_b = {16'b0, f};
      end
      default: begin
        mul_a = total;
        mul_b = total;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign y    = t_rd[39:32];
  assign tsum = {1'b0, total} + {1'b0, comp};
  assign s1   = {1'b0, sum_acc} + {3'b0, total, 14'b0};
  assign s2   = {1'b0, sq_acc} + {3'b0, sq_add};
  assign n1   = s1[48] ? ACC_MAX : s1[47:0];
  assign n2   = s2[48] ? ACC_MAX : s2[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc_in && act == ACT_CENTER && ld_ok_ct) begin
          state_next = ST_DIV;
        end else if (acc_in && act == ACT_RUN) begin
          state_next = ST_INIT;
        end
      end
      ST_DIV:   if (drsp.done) state_next = ST_IDLE;
      ST_INIT: begin
        if (rstart[li] > rstop[li]) begin
          state_next = ST_DONE;
        end else if (l == nl - LW'(1)) begin
          state_next = ST_VEC;
        end
      end
      ST_VEC:   state_next = ST_WRD;
      ST_WRD:   state_next = ST_WGET;
      ST_WGET:  state_next = (w_rd == 16'd0) ? ST_CEND : ST_LRD;
      ST_LRD:   state_next = ST_LGET;
      ST_LGET:  state_next = ST_POW;
      ST_POW:   if (d == 8'd0 || f == 16'd0) state_next = ST_CMUL;
      ST_CMUL:  state_next = ST_LNEXT;
      ST_LNEXT: state_next = (l < nl && comp != 32'd0) ? ST_LRD : ST_CEND;
      ST_CEND:  state_next = (c + CW'(1) < nc) ? ST_WRD : ST_SQ;
      ST_SQ:    state_next = ST_ACC;
      ST_ACC:   state_next = (n1 == ACC_MAX && n2 == ACC_MAX) ? ST_DONE : ST_INC;
      ST_INC: begin
        if (cnt[li] < rstop[li]) begin
          state_next = ST_VEC;
        end else if (l == LW'(0)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // loop datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc <= '0;
      sq_acc  <= '0;
      sat     <= 1'b0;
      l       <= '0;
      c       <= '0;
      nl      <= LW'(1);
      nc      <= CW'(1);
      for (int i = 0; i < MAX_LOCI; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc_in) begin
            h_addr   <= TAW'(32'(in_ch.cluster) * MAX_LOCI + 32'(in_ch.locus));
            h_center <= in_ch.allele_a;
            h_decay  <= in_ch.decay;
            if (act == ACT_RANGE && ld_ok_r) begin
              rstart[LIW'(in_ch.locus)] <= in_ch.allele_a;
              rstop[LIW'(in_ch.locus)]  <= in_ch.allele_b;
            end
            if (act == ACT_RUN) begin
              sum_acc <= '0;
              sq_acc  <= '0;
              sat     <= 1'b0;
              l       <= '0;
              if (loci_cfg == 5'd0) nl <= LW'(1);
              else if (32'(loci_cfg) > MAX_LOCI) nl <= LW'(MAX_LOCI);
              else nl <= LW'(loci_cfg);
              if (clus_cfg == 5'd0) nc <= CW'(1);
              else if (32'(clus_cfg) > MAX_CLUSTERS) nc <= CW'(MAX_CLUSTERS);
              else nc <= CW'(clus_cfg);
            end
          end
        end
        ST_INIT: begin
          cnt[li] <= rstart[li];
          l       <= l + LW'(1);
        end
        ST_VEC: begin
          c     <= '0;
          total <= '0;
        end
        ST_WGET: begin
          comp <= {w_rd, 16'b0};
          l    <= '0;
        end
        ST_LGET: begin
          d   <= (cnt[li] > y) ? cnt[li] - y : y - cnt[li];
          f   <= t_rd[15:0];
          p_r <= t_rd[31:16];
        end
        ST_POW: begin
          if (d != 8'd0 && f != 16'd0) begin
            f <= prod[31:16];
            d <= d - 8'd1;
          end
        end
        ST_CMUL: begin
          comp <= prod[47:16];
          l    <= l + LW'(1);
        end
        ST_CEND: begin
          total <= tsum[32] ? PROB_MAX : tsum[31:0];
          c     <= c + CW'(1);
        end
        ST_SQ: sq_add <= prod[63:18];
        ST_ACC: begin
          sum_acc <= n1;
          sq_acc  <= n2;
          if (s1[48] || s2[48]) sat <= 1'b1;
          l <= nl - LW'(1);
        end
        ST_INC: begin
          if (cnt[li] < rstop[li]) begin
            cnt[li] <= cnt[li] + 8'd1;
          end else begin
            cnt[li] <= rstart[li];
            l       <= l - LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else begin
      if (out_ch.ready) ov <= 1'b0;
      if (state == ST_DONE && out_free) begin
        ov    <= 1'b1;
        o_sum <= sum_acc;
        o_sq  <= sq_acc;
        o_sat <= sat;
      end
    end
  end

  assign out_ch.valid       = ov;
  assign out_ch.prob_sum    = o_sum;
  assign out_ch.prob_sq_sum = o_sq;
  assign out_ch.saturated   = o_sat;
endmodule

>>> rtl/core/lmps_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module lmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/lmps_div.sv
// Restoring divider for (1-p)/(1+p) in Q0.16, one quotient bit a cycle.
// Depends on lmps_pkg.
module lmps_div
  import lmps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [17:0] rem;
  logic [16:0] den;
  logic [16:0] quo;
  logic        nbit;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [17:0] trial;
  logic [16:0] num_hi;

  assign trial  = {rem[16:0], nbit};
  assign num_hi = 17'h10000 - {1'b0, req.p};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        rem  <= {2'b0, num_hi[16:1]};
        nbit <= num_hi[0];
        den  <= 17'h10000 + {1'b0, req.p};
        quo  <= '0;
      end else if (busy) begin
        nbit <= 1'b0;
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[15:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = quo[16] ? 16'hFFFF : quo[15:0];
endmodule

>>> rtl/core/lmps_chk.sv
// Port checker for the mixture core, bound to the top level.
// Depends on lmps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lmps_chk
  import lmps_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_sum,
  input logic [47:0] out_sq,
  input logic        out_sat,
  input logic        pready
);
  `LMPS_ASSERT_NEXT(a_run_busy, in_valid && in_ready && in_action == ACT_RUN, !in_ready)
  `LMPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_sum) && $stable(out_sq) && $stable(out_sat))
  `LMPS_ASSERT_NOW(a_sat_max, out_valid && out_sat, out_sum == ACC_MAX || out_sq == ACC_MAX)
  `LMPS_ASSERT_NOW(a_pready, 1'b1, pready)
endmodule

bind laplace_mixture_prob_sums_core lmps_chk u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_sum(out_ch.prob_sum), .out_sq(out_ch.prob_sq_sum), .out_sat(out_ch.saturated),
  .pready(pready)
);

>>> sim/lmps_checker.sv
`timescale 1ns / 100ps
// Checker for the Laplace mixture core: watches the item channels and the APB
// port, predicts each run's sums and compares. Depends on lmps_pkg and lmps_if.
module lmps_checker
  import lmps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lmps_in_if                 in_ch,
  lmps_out_if                out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  localparam int NLOC = DEF_MAX_LOCI;
  localparam int NCLU = DEF_MAX_CLUSTERS;

  typedef struct packed {
    logic [47:0] prob_sum;
    logic [47:0] prob_sq_sum;
    logic        saturated;
  } sums_t;

  logic [4:0]  loci_reg, clust_reg;
  logic [7:0]  centre_mem [NLOC*NCLU];
  logic [15:0] decay_mem  [NLOC*NCLU];
  logic [15:0] scale_mem  [NLOC*NCLU];
  logic [15:0] tau_mem    [NCLU];
  logic [7:0]  lo_mem     [NLOC];
  logic [7:0]  hi_mem     [NLOC];
  sums_t       sums_q[$];

  assign pending = sums_q.size();

  function automatic logic [15:0] ratio_q16(logic [15:0] p);
    longint unsigned q;
    q = ((longint'(65536) - p) << 16) / (longint'(65536) + p);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic sums_t mixture_sums();
    int nl, nc, l, c, k, d;
    logic [7:0] alle [NLOC];
    longint unsigned total, comp, f, pr, s1, s2;
    logic sat, more;
    sums_t r;
    nl = (loci_reg == 0) ? 1 : (loci_reg > NLOC) ? NLOC : loci_reg;
    nc = (clust_reg == 0) ? 1 : (clust_reg > NCLU) ? NCLU : clust_reg;
    s1 = 0; s2 = 0; sat = 0;
    r = '0;
    for (l = 0; l < nl; l++) begin
      if (lo_mem[l] > hi_mem[l]) return r;
      alle[l] = lo_mem[l];
    end
    forever begin
      total = 0;
      for (c = 0; c < nc; c++) begin
        comp = longint'(tau_mem[c]) << 16;
        for (l = 0; l < nl && comp != 0; l++) begin
          d = (alle[l] > centre_mem[c*NLOC+l]) ? alle[l] - centre_mem[c*NLOC+l]
                                               : centre_mem[c*NLOC+l] - alle[l];
          f = scale_mem[c*NLOC+l];
          for (k = 0; k < d && f != 0; k++) f = (f * decay_mem[c*NLOC+l]) >> 16;
          comp = (comp * f) >> 16;
        end
        total += comp;
      end
      pr = (total > PROB_MAX) ? PROB_MAX : total;
      s1 += pr << 14;
      if (s1 > ACC_MAX) begin s1 = ACC_MAX; sat = 1; end
      s2 += (pr * pr) >> 18;
      if (s2 > ACC_MAX) begin s2 = ACC_MAX; sat = 1; end
      more = 0;
      for (l = nl - 1; l >= 0; l--) begin
        if (alle[l] < hi_mem[l]) begin
          alle[l]++;
          more = 1;
          break;
        end
        alle[l] = lo_mem[l];
      end
      if (!more) break;
    end
    r.prob_sum = s1[47:0];
    r.prob_sq_sum = s2[47:0];
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      loci_reg <= 5'd1;
      clust_reg <= 5'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel_t'(paddr[2]) == REG_LOCI) loci_reg <= pwdata[4:0];
      else clust_reg <= pwdata[4:0];
    end
  end

  always @(posedge clk) begin
    int idx;
    sums_t got, want;
    if (rst) begin
      fail_count <= 0;
      sums_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        idx = in_ch.cluster * NLOC + in_ch.locus;
        case (action_t'(in_ch.action))
          ACT_CENTER: begin
            centre_mem[idx] = in_ch.allele_a;
            decay_mem[idx] = in_ch.decay;
            scale_mem[idx] = ratio_q16(in_ch.decay);
          end
          ACT_WEIGHT: tau_mem[in_ch.cluster] = in_ch.weight;
          ACT_RANGE: begin
            lo_mem[in_ch.locus] = in_ch.allele_a;
            hi_mem[in_ch.locus] = in_ch.allele_b;
          end
          ACT_RUN: sums_q.insert(sums_q.size(), mixture_sums());
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.prob_sum, out_ch.prob_sq_sum, out_ch.saturated};
        if (sums_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", got);
        end else begin
          want = sums_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: sum %h/%h sq %h/%h sat %b/%b (exp/got)",
                       want.prob_sum, got.prob_sum, want.prob_sq_sum,
                       got.prob_sq_sum, want.saturated, got.saturated);
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for laplace_mixture_prob_sums_core: stimulus, APB set-up,
// receiver stalls and verdict. Depends on lmps_pkg, lmps_if and lmps_checker.
module tb_top;
  import lmps_pkg::*;

  localparam int WATCH_LIMIT = 200000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;

  lmps_in_if in_ch();
  lmps_out_if out_ch();

  laplace_mixture_prob_sums_core u_top (
    .clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lmps_checker u_chk (
    .clk, .rst, .in_ch, .out_ch, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .fail_count, .pending
  );

  always #6 clk = ~clk;

  // shadow of what has been loaded, to keep runs legal and short
  bit         cen_ok [16][16];
  logic [7:0] cen_val [16][16];
  bit         wt_ok [16];
  bit         rng_ok [16];
  logic [7:0] rs [16], re [16];
  int nl_e = 1, nc_e = 1;
  int burst_left = 4;
  bit vld_hi = 0;

  // receiver stall pattern: mode redrawn at random whenever rx_cnt[5:0] is zero
  int unsigned rx_cnt = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt[5:0] == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 0);
      2: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default: out_ch.ready <= rx_cnt[3];
    endcase
  end

  int idle_cnt = 0;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCH_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send(action_t act, int cl, int lo, int a, int b, int dec, int wt);
    case (act)
      ACT_CENTER: begin cen_ok[cl][lo] = 1; cen_val[cl][lo] = 8'(a); end
      ACT_WEIGHT: wt_ok[cl] = 1;
      ACT_RANGE: begin rng_ok[lo] = 1; rs[lo] = 8'(a); re[lo] = 8'(b); end
      default: ;
    endcase
    in_ch.action <= act;
    in_ch.cluster <= 4'(cl);
    in_ch.locus <= 4'(lo);
    in_ch.allele_a <= 8'(a);
    in_ch.allele_b <= 8'(b);
    in_ch.decay <= 16'(dec);
    in_ch.weight <= 16'(wt);
    in_ch.valid <= 1'b1;
    vld_hi = 1;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    if (--burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      vld_hi = 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  task automatic reg_write(reg_sel_t r, int val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    if (vld_hi) begin
      in_ch.valid <= 1'b0;
      vld_hi = 0;
    end
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_phase(int loci, int clus);
    drain();
    reg_write(REG_LOCI, loci);
    reg_write(REG_CLUST, clus);
    nl_e = (loci == 0) ? 1 : (loci > 16) ? 16 : loci;
    nc_e = (clus == 0) ? 1 : (clus > 16) ? 16 : clus;
  endtask

  function automatic int rnd_allele(bit wide);
    return (wide && $urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(96, 111);
  endfunction

  function automatic int rnd_decay();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rnd_weight();
    return ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 65535);
  endfunction

  // loads whatever a run would read unwritten, bounds its length, then sends the run item
  task automatic run_item();
    bit wide;
    longint vec;
    int c, l, s;
    wide = (nl_e * nc_e <= 4);
    for (c = 0; c < nc_e; c++) begin
      if (!wt_ok[c]) send(ACT_WEIGHT, c, $urandom_range(0, 15), 0, 0, 0, rnd_weight());
      for (l = 0; l < nl_e; l++)
        if (!cen_ok[c][l] || (!wide && (cen_val[c][l] < 96 || cen_val[c][l] > 111)))
          send(ACT_CENTER, c, l, rnd_allele(0), 0, rnd_decay(), 0);
    end
    vec = 1;
    for (l = 0; l < nl_e; l++) begin
      if (!rng_ok[l] || (!wide && rs[l] <= re[l] && (rs[l] < 96 || re[l] > 111))) begin
        s = rnd_allele(0);
        send(ACT_RANGE, $urandom_range(0, 15), l, s, s + $urandom_range(0, 1), 0, 0);
        send(ACT_RANGE, 0, l, s, s + $urandom_range(0, 1), 0, 0);
      end
      if (rs[l] > re[l]) vec = 0;
      else if (vec < 1000) vec *= re[l] - rs[l] + 1;
    end
    if (vec > ((nl_e * nc_e >= 64) ? 1 : 8))
      for (l = 0; l < nl_e; l++) begin
        s = rnd_allele(0);
        send(ACT_RANGE, 0, l, s, s, 0, 0);
      end
    send(ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
         $urandom_range(0, 255), $urandom_range(0, 255),
         $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  task automatic random_items(int n);
    int i, s;
    bit wide;
    for (i = 0; i < n; i++) begin
      wide = (nl_e * nc_e <= 4);
      case ($urandom_range(0, 9))
        0, 1: run_item();
        2, 3, 4: send(ACT_CENTER, $urandom_range(0, nc_e - 1), $urandom_range(0, nl_e - 1),
                      rnd_allele(wide), $urandom_range(0, 255), rnd_decay(),
                      $urandom_range(0, 65535));
        5, 6: send(ACT_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 65535), rnd_weight());
        7: send(ACT_CENTER, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
        default: begin
          s = rnd_allele(wide);
          if (wide && $urandom_range(0, 3) == 0)
            send(ACT_RANGE, $urandom_range(0, 15), $urandom_range(0, nl_e - 1),
                 $urandom_range(0, 255), $urandom_range(0, 255), 0, 0);
          else
            send(ACT_RANGE, $urandom_range(0, 15), $urandom_range(0, nl_e - 1), s,
                 ($urandom_range(0, 7) == 0) ? s - 1 : s + $urandom_range(0, 2),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.action = '0; in_ch.cluster = '0; in_ch.locus = '0;
    in_ch.allele_a = '0; in_ch.allele_b = '0; in_ch.decay = '0; in_ch.weight = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // directed: single cluster, single locus
    send(ACT_CENTER, 0, 0, 0, 0, 0, 0);
    send(ACT_WEIGHT, 0, 0, 0, 0, 0, 16'hFFFF);
    send(ACT_RANGE, 0, 0, 0, 0, 0, 0);
    send(ACT_RUN, 0, 0, 0, 0, 0, 0);
    send(ACT_RANGE, 0, 0, 0, 7, 0, 0);
    send(ACT_RUN, 0, 0, 0, 0, 0, 0);
    send(ACT_CENTER, 15, 15, 255, 255, 16'hFFFF, 16'hFFFF);
    send(ACT_CENTER, 0, 0, 255, 255, 16'hFFFF, 16'hFFFF);
    send(ACT_RANGE, 0, 0, 0, 2, 0, 0);
    send(ACT_RUN, 15, 15, 255, 255, 16'hFFFF, 16'hFFFF);
    send(ACT_RANGE, 15, 0, 255, 255, 16'hFFFF, 16'hFFFF);
    send(ACT_RUN, 0, 0, 0, 0, 0, 0);
    send(ACT_WEIGHT, 0, 0, 0, 0, 0, 0);
    send(ACT_RUN, 0, 0, 0, 0, 0, 0);
    send(ACT_WEIGHT, 15, 15, 255, 255, 16'hFFFF, 16'hFFFF);
    send(ACT_WEIGHT, 0, 0, 0, 0, 0, 16'h8000);
    send(ACT_RANGE, 0, 0, 5, 3, 0, 0);
    send(ACT_RUN, 0, 0, 0, 0, 0, 0);
    send(ACT_CENTER, 0, 0, 128, 0, 16'h8000, 0);
    send(ACT_RANGE, 0, 0, 0, 255, 0, 0);
    send(ACT_RUN, 0, 0, 0, 0, 0, 0);
    send(ACT_RANGE, 15, 15, 255, 0, 0, 0);

    random_items(90);
    set_phase(2, 3);   random_items(110);
    set_phase(16, 16); random_items(110);
    set_phase(0, 31);  random_items(110);
    set_phase(31, 0);  random_items(110);
    set_phase(4, 2);   random_items(110);
    set_phase(1, 16);  random_items(100);
    set_phase(3, 3);   random_items(100);

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

>>> laplace_mixture_prob_sums_core.f
+incdir+rtl/core
rtl/core/lmps_pkg.sv
rtl/core/lmps_if.sv
rtl/core/lmps_ram.sv
rtl/core/lmps_div.sv
rtl/core/laplace_mixture_prob_sums_core.sv
rtl/core/lmps_chk.sv
sim/lmps_checker.sv
sim/tb_top.sv
